FILE: design/kslp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kslp_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int SCAN_KEYS   = 4;
    localparam int CNT_W       = 8;
    localparam int CFG_W       = 8;
    localparam int PH_W        = 2;
    localparam int KIND_W      = 2;
    localparam int SEL_W       = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [PH_W-1:0] PH_UNPRESSED = 2'd0;
    localparam logic [PH_W-1:0] PH_PRESSED   = 2'd1;
    localparam logic [PH_W-1:0] PH_HOLD      = 2'd2;
    localparam logic [PH_W-1:0] PH_RELEASED  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_LONG     = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd2;
    localparam logic [CFG_W-1:0] LONG_RST     = 8'd100;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;

    typedef struct packed {
        logic scan;
        logic down;
        logic clr;
    } t_lane_ctl;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_cnt;
    } t_cfg;

endpackage
`default_nettype wire

FILE: design/kslp_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module kslp_lane (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire kslp_pkg::t_lane_ctl        i_ctl,
    input  wire kslp_pkg::t_cfg             i_cfg,
    output logic [kslp_pkg::KIND_W-1:0]     o_latch,
    output logic [kslp_pkg::KIND_W-1:0]     o_latch_next
);

    logic [kslp_pkg::PH_W-1:0]   r_phase, n_phase;
    logic [kslp_pkg::CNT_W-1:0]  r_count, n_count;
    logic [kslp_pkg::KIND_W-1:0] r_latch, n_latch;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_latch = r_latch;
        if (i_ctl.clr) begin
            n_latch = kslp_pkg::KIND_NONE;
        end else if (i_ctl.scan) begin
            case (r_phase)
                kslp_pkg::PH_UNPRESSED: begin
                    if (i_ctl.down) begin
                        n_phase = kslp_pkg::PH_PRESSED;
                    end
                end
                kslp_pkg::PH_PRESSED: begin
                    n_phase = kslp_pkg::PH_HOLD;
                end
                kslp_pkg::PH_HOLD: begin
                    if (r_count != kslp_pkg::CNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    if (n_count >= i_cfg.debounce && !i_ctl.down) begin
                        n_phase = kslp_pkg::PH_RELEASED;
                        if (r_latch != kslp_pkg::KIND_LONG) begin
                            n_latch = kslp_pkg::KIND_SHORT;
                        end
                    end
                    if (n_count >= i_cfg.long_cnt) begin
                        n_latch = kslp_pkg::KIND_LONG;
                    end
                end
                default: begin
                    n_count = '0;
                    n_phase = kslp_pkg::PH_UNPRESSED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kslp_pkg::PH_UNPRESSED;
            r_count <= '0;
            r_latch <= kslp_pkg::KIND_NONE;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_latch <= n_latch;
        end
    end

    assign o_latch      = r_latch;
    assign o_latch_next = n_latch;

endmodule
`default_nettype wire

FILE: design/kslp_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module kslp_merge (
    input  wire                             i_read,
    input  wire [kslp_pkg::SEL_W-1:0]       i_sel,
    input  wire [kslp_pkg::KIND_W-1:0]      i_latch [kslp_pkg::NUM_KEYS],
    input  wire [kslp_pkg::KIND_W-1:0]      i_latch_next [kslp_pkg::NUM_KEYS],
    output logic [kslp_pkg::KIND_W-1:0]     o_kind,
    output logic [kslp_pkg::SCAN_KEYS-1:0]  o_pending
);

    always_comb begin
        o_kind    = kslp_pkg::KIND_NONE;
        o_pending = '0;
        for (int i = 0; i < kslp_pkg::NUM_KEYS; i++) begin
            if (i_read && (32'(i_sel) == i)) begin
                o_kind = i_latch[i];
            end
            if (i < kslp_pkg::SCAN_KEYS) begin
                o_pending[i] = (i_latch_next[i] != kslp_pkg::KIND_NONE);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/key_short_long_press_detector_top.sv
// Short/long key-press classifier for up to four keys, one lane per key.
// Input stream (s_axis): tuser carries the command; each transfer is either a
// scan tick whose tdata carries every key level or a read that returns the
// latched press kind of the key named in tdata and clears it.
// Output stream (m_axis): one result transfer per input transfer, in order,
// giving the press kind (zero on scan) and the mask of keys with a latched
// press after the item.
// The result sits in the output register on the cycle after the input
// transfer. Throughput: one item per cycle while the receiver is ready;
// all key lanes update in parallel and the merge stage feeds the output
// register. A stalled receiver holds the output register; the input side
// keeps taking items as long as the output register is empty or is being
// drained in the same cycle.
// Configuration: write debounce (index 0) or long count (index 1) on the
// write port while the block is idle; writes take effect at the next edge.
// Reset (synchronous, active low): keys unpressed, counters and latches
// cleared, debounce 2, long count 100, output empty.
`timescale 1ns / 1ps
`default_nettype none
module key_short_long_press_detector_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire                                 i_cfg_index,
    input  wire [kslp_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] keys_down, [5:4] key_select, [7:6] zero
    input  wire [kslp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] cmd
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [1:0] press_kind, [5:2] pending_mask, [7:6] zero
    output logic [kslp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    kslp_pkg::t_cfg r_cfg;

    logic                                 w_accept;
    logic                                 w_cmd;
    logic [kslp_pkg::SCAN_KEYS-1:0]       w_keys;
    logic [kslp_pkg::SEL_W-1:0]           w_sel;
    logic [kslp_pkg::KIND_W-1:0]          w_latch      [kslp_pkg::NUM_KEYS];
    logic [kslp_pkg::KIND_W-1:0]          w_latch_next [kslp_pkg::NUM_KEYS];
    logic [kslp_pkg::KIND_W-1:0]          w_kind;
    logic [kslp_pkg::SCAN_KEYS-1:0]       w_pending;
    logic                                 r_out_valid;
    logic [kslp_pkg::KIND_W-1:0]          r_out_kind;
    logic [kslp_pkg::SCAN_KEYS-1:0]       r_out_pending;

    assign w_cmd  = s_axis_tuser;
    assign w_keys = s_axis_tdata[3:0];
    assign w_sel  = s_axis_tdata[5:4];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= kslp_pkg::DEBOUNCE_RST;
            r_cfg.long_cnt <= kslp_pkg::LONG_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                kslp_pkg::CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_wdata;
                kslp_pkg::CFG_LONG:     r_cfg.long_cnt <= i_cfg_wdata;
                default:                r_cfg <= r_cfg;
            endcase
        end
    end

    for (genvar g = 0; g < kslp_pkg::NUM_KEYS; g++) begin : g_lane
        kslp_pkg::t_lane_ctl w_ctl;

        assign w_ctl.scan = w_accept && (w_cmd == kslp_pkg::CMD_SCAN);
        assign w_ctl.clr  = w_accept && (w_cmd == kslp_pkg::CMD_READ)
                            && (32'(w_sel) == g);
        if (g < kslp_pkg::SCAN_KEYS) begin : g_in
            assign w_ctl.down = w_keys[g];
        end else begin : g_no_in
            assign w_ctl.down = 1'b0;
        end

        kslp_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cfg        (r_cfg),
            .o_latch      (w_latch[g]),
            .o_latch_next (w_latch_next[g])
        );
    end

    kslp_merge u_merge (
        .i_read       (w_cmd == kslp_pkg::CMD_READ),
        .i_sel        (w_sel),
        .i_latch      (w_latch),
        .i_latch_next (w_latch_next),
        .o_kind       (w_kind),
        .o_pending    (w_pending)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_kind    <= w_kind;
            r_out_pending <= w_pending;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_pending, r_out_kind};

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    a_scan_kind_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == kslp_pkg::CMD_SCAN) |=> (r_out_kind == kslp_pkg::KIND_NONE))
        else $error("scan result carries a press kind");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_kind == kslp_pkg::KIND_NONE
                           || r_out_kind == kslp_pkg::KIND_SHORT
                           || r_out_kind == kslp_pkg::KIND_LONG))
        else $error("illegal press kind");

    a_read_clears_key0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == kslp_pkg::CMD_READ && w_sel == 2'd0)
        |=> !r_out_pending[0])
        else $error("read left key 0 pending");

endmodule
`default_nettype wire
